FILE: rtl/core/ryc_pkg.sv
// Shared types, constants and width helpers for the RGB / YPbPr converter.
`default_nettype none

package ryc_pkg;

  localparam int NCH      = 3;
  localparam int IN_W     = 17;
  localparam int OUT0_W   = 16;
  localparam int OUT12_W  = 17;
  localparam int COEF_W   = 22;
  localparam int PROD_W   = 39;
  localparam int SUM_W    = 39;
  localparam int Q_W      = 18;
  localparam int FRONT_ST = 5;
  localparam int DENOM_W  = 16;
  localparam int DFWD_W   = 36;
  localparam int HALF_W   = 35;
  localparam int REG_IDX_W = 1;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DENOM     = 1'b1;

  localparam logic [DENOM_W-1:0] DENOM_RST    = 16'd255;
  localparam logic [19:0]        MILLION      = 20'd1000000;
  localparam logic [18:0]        HALF_MILLION = 19'd500000;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic           vld;
    logic           dir;
    logic [NCH-1:0] neg;
  } ryc_ctl_t;

  // Matrix coefficients in millionths, indexed by output channel then input.
  localparam coef_t COEF_FWD [NCH][NCH] = '{
    '{ 22'sd299000,  22'sd587000,  22'sd114000},
    '{-22'sd168736, -22'sd331264,  22'sd500000},
    '{ 22'sd500000, -22'sd418688, -22'sd81312 }
  };

  localparam coef_t COEF_REV [NCH][NCH] = '{
    '{ 22'sd1000000,  22'sd0,        22'sd1402000},
    '{ 22'sd1000000, -22'sd344136,  -22'sd714136 },
    '{ 22'sd1000000,  22'sd1772000,  22'sd0      }
  };

  function automatic int v_width(int f);
    return (f + 20 > 37) ? f + 20 : 37;
  endfunction

  function automatic int num_width(int f);
    return f + 37;
  endfunction

  function automatic int cmp_width(int f);
    return (num_width(f) > v_width(f) + Q_W - 1) ? num_width(f) : v_width(f) + Q_W - 1;
  endfunction

  function automatic logic [63:0] full_scale(int f);
    return 64'd1000000 << f;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ryc_front.sv
// Front pipeline: input capture, matrix products, sums, clamp or magnitude, and numerator build.
`default_nettype none

module ryc_front
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      acc_i,
  input  logic                                      dir_i,
  input  logic [OUT0_W-1:0]                         first_i,
  input  logic signed [IN_W-1:0]                    second_i,
  input  logic signed [IN_W-1:0]                    third_i,
  input  logic [DENOM_W-1:0]                        denom_i,
  input  logic [HALF_W-1:0]                         half_i,
  output ryc_ctl_t                                  ctl_o,
  output logic [NCH-1:0][num_width(FRAC_BITS)-1:0] num_o
);

  localparam int V_W   = v_width(FRAC_BITS);
  localparam int NUM_W = num_width(FRAC_BITS);
  localparam int CL_W  = ((V_W > SUM_W) ? V_W : SUM_W) + 1;
  localparam logic [V_W-1:0]         FULL   = V_W'(full_scale(FRAC_BITS));
  localparam logic signed [CL_W-1:0] FULL_X = CL_W'(FULL);

  ryc_ctl_t a_ctl_r, b_ctl_r, c_ctl_r, d_ctl_r, e_ctl_r;
  ryc_ctl_t a_ctl_nxt, d_ctl_nxt;

  logic signed [IN_W-1:0]   a_x_r    [NCH];
  logic signed [PROD_W-1:0] b_prod_r [NCH][NCH];
  logic signed [SUM_W-1:0]  c_sum_r  [NCH];
  logic signed [CL_W-1:0]   sum_x    [NCH];
  logic [V_W-1:0]           d_val_r  [NCH];
  logic [V_W-1:0]           d_val_nxt [NCH];
  logic [V_W+DENOM_W-1:0]   rev_prod [NCH];
  logic [NUM_W-1:0]         e_num_r  [NCH];
  logic [NUM_W-1:0]         e_num_nxt [NCH];

  always_comb begin
    a_ctl_nxt     = '0;
    a_ctl_nxt.vld = acc_i;
    a_ctl_nxt.dir = dir_i;
  end

  always_comb begin
    d_ctl_nxt = c_ctl_r;
    for (int ch = 0; ch < NCH; ch++) begin
      sum_x[ch]         = CL_W'(c_sum_r[ch]);
      d_ctl_nxt.neg[ch] = c_sum_r[ch][SUM_W-1];
      if (c_ctl_r.dir == DIR_REV) begin
        if (c_sum_r[ch][SUM_W-1]) begin
          d_val_nxt[ch] = '0;
        end else if (sum_x[ch] > FULL_X) begin
          d_val_nxt[ch] = FULL;
        end else begin
          d_val_nxt[ch] = V_W'(c_sum_r[ch]);
        end
      end else begin
        d_val_nxt[ch] = V_W'(c_sum_r[ch][SUM_W-1] ? -c_sum_r[ch] : c_sum_r[ch]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      rev_prod[ch] = d_val_r[ch] * denom_i;
      if (d_ctl_r.dir == DIR_REV) begin
        e_num_nxt[ch] = NUM_W'(rev_prod[ch]);
      end else begin
        e_num_nxt[ch] = (NUM_W'(d_val_r[ch]) << FRAC_BITS) + NUM_W'(half_i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
      d_ctl_r <= '0;
      e_ctl_r <= '0;
    end else begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= a_ctl_r;
      c_ctl_r <= b_ctl_r;
      d_ctl_r <= d_ctl_nxt;
      e_ctl_r <= d_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    a_x_r[0] <= {1'b0, first_i};
    a_x_r[1] <= second_i;
    a_x_r[2] <= third_i;
    for (int ch = 0; ch < NCH; ch++) begin
      for (int k = 0; k < NCH; k++) begin
        b_prod_r[ch][k] <= PROD_W'(a_ctl_r.dir ? COEF_REV[ch][k] : COEF_FWD[ch][k])
                           * PROD_W'(a_x_r[k]);
      end
      c_sum_r[ch] <= b_prod_r[ch][0] + b_prod_r[ch][1] + b_prod_r[ch][2];
      d_val_r[ch] <= d_val_nxt[ch];
      e_num_r[ch] <= e_num_nxt[ch];
    end
  end

  assign ctl_o = e_ctl_r;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      num_o[ch] = e_num_r[ch];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ryc_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes.
`default_nettype none

module ryc_div
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ryc_ctl_t                                  ctl_i,
  input  logic [NCH-1:0][num_width(FRAC_BITS)-1:0] num_i,
  input  logic [DFWD_W-1:0]                         dfwd_i,
  output ryc_ctl_t                                  ctl_o,
  output logic [NCH-1:0][Q_W-1:0]                   q_o
);

  localparam int V_W   = v_width(FRAC_BITS);
  localparam int CMP_W = cmp_width(FRAC_BITS);
  localparam logic [V_W-1:0] FULL = V_W'(full_scale(FRAC_BITS));

  ryc_ctl_t         ctl_r [Q_W];
  logic [CMP_W-1:0] rem_r [Q_W][NCH];
  logic [Q_W-1:0]   q_r   [Q_W][NCH];
  logic [CMP_W-1:0] d_last;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int SH = Q_W - 1 - j;

    ryc_ctl_t         ctl_in;
    logic [CMP_W-1:0] rem_in  [NCH];
    logic [Q_W-1:0]   q_in    [NCH];
    logic [CMP_W-1:0] dsh;
    logic [NCH-1:0]   ge;
    logic [CMP_W-1:0] rem_nxt [NCH];
    logic [Q_W-1:0]   q_nxt   [NCH];

    if (j == 0) begin : g_head
      always_comb begin
        ctl_in = ctl_i;
        for (int ch = 0; ch < NCH; ch++) begin
          rem_in[ch] = CMP_W'(num_i[ch]);
          q_in[ch]   = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        ctl_in = ctl_r[j-1];
        for (int ch = 0; ch < NCH; ch++) begin
          rem_in[ch] = rem_r[j-1][ch];
          q_in[ch]   = q_r[j-1][ch];
        end
      end
    end

    always_comb begin
      dsh = CMP_W'((ctl_in.dir == DIR_REV) ? FULL : V_W'(dfwd_i)) << SH;
      for (int ch = 0; ch < NCH; ch++) begin
        ge[ch]      = rem_in[ch] >= dsh;
        rem_nxt[ch] = ge[ch] ? rem_in[ch] - dsh : rem_in[ch];
        q_nxt[ch]   = {q_in[ch][Q_W-2:0], ge[ch]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else begin
        ctl_r[j] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      for (int ch = 0; ch < NCH; ch++) begin
        rem_r[j][ch] <= rem_nxt[ch];
        q_r[j][ch]   <= q_nxt[ch];
      end
    end
  end

  assign ctl_o  = ctl_r[Q_W-1];
  assign d_last = CMP_W'((ctl_o.dir == DIR_REV) ? FULL : V_W'(dfwd_i));

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      q_o[ch] = q_r[Q_W-1][ch];
    end
  end

  for (genvar ch = 0; ch < NCH; ch++) begin : g_chk
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
      (ctl_o.vld && !q_o[ch][Q_W-1]) |-> (rem_r[Q_W-1][ch] < d_last))
      else $error("Divider remainder is not below the divisor.");
  end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_ypbpr_convert.sv
// Top level of the RGB / YPbPr color converter with its configuration registers.
//
// Channel   Ports                                    Handshake
// input     in_first, in_second, in_third            accepted when start is high, busy low
// result    out_first, out_second, out_third         out_valid strobe for one cycle
// config    cfg_index, cfg_data                      written when cfg_we is high
//
// One transaction can be accepted every clock while busy is low; busy is high only while rst_n is low.
// The result strobe follows the accepting edge through five front stages,
// the 18-stage divider and the output register.
// Synchronous reset clears every valid bit and loads direction 0 and denom 255.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module rgb_ypbpr_convert
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OUT0_W-1:0]          in_first,
  input  logic signed [IN_W-1:0]     in_second,
  input  logic signed [IN_W-1:0]     in_third,
  output logic                       out_valid,
  output logic [OUT0_W-1:0]          out_first,
  output logic signed [OUT12_W-1:0]  out_second,
  output logic signed [OUT12_W-1:0]  out_third,
  input  logic                       cfg_we,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [DENOM_W-1:0]         cfg_data
);

  localparam int LAT  = FRONT_ST + Q_W + 1;
  localparam int SV_W = Q_W + 1;
  localparam int NUM_W = num_width(FRAC_BITS);
  localparam logic [Q_W-1:0]         MAG_CAP = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [SV_W-1:0] Y_MAX   = SV_W'(65535);
  localparam logic signed [SV_W-1:0] C_MIN   = SV_W'(-32768);
  localparam logic [DFWD_W-1:0] DFWD_RST = DFWD_W'(DENOM_RST) * DFWD_W'(MILLION);
  localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(DENOM_RST) * HALF_W'(HALF_MILLION);

  logic                 in_acc;
  logic                 dir_r;
  logic [DENOM_W-1:0]   denom_r;
  logic [DFWD_W-1:0]    dfwd_r;
  logic [HALF_W-1:0]    half_r;

  ryc_ctl_t                    front_ctl;
  logic [NCH-1:0][NUM_W-1:0]   front_num;
  ryc_ctl_t                    div_ctl;
  logic [NCH-1:0][Q_W-1:0]     div_q;

  logic [Q_W-1:0]              mag  [NCH];
  logic signed [SV_W-1:0]      sval [NCH];
  logic                        out_valid_r;
  logic [OUT0_W-1:0]           out_first_r, out_first_nxt;
  logic signed [OUT12_W-1:0]   out_second_r, out_second_nxt;
  logic signed [OUT12_W-1:0]   out_third_r, out_third_nxt;

  function automatic logic signed [OUT12_W-1:0] chroma_sat(input logic signed [SV_W-1:0] v);
    if (v < C_MIN) begin
      return OUT12_W'(C_MIN);
    end else if (v > Y_MAX) begin
      return OUT12_W'(Y_MAX);
    end
    return v[OUT12_W-1:0];
  endfunction

  assign busy   = ~rst_n;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_FWD;
      denom_r <= DENOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION: dir_r   <= cfg_data[0];
        REG_DENOM:     denom_r <= (cfg_data == '0) ? DENOM_W'(1) : cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfwd_r <= DFWD_RST;
      half_r <= HALF_RST;
    end else begin
      dfwd_r <= DFWD_W'(denom_r) * DFWD_W'(MILLION);
      half_r <= HALF_W'(denom_r) * HALF_W'(HALF_MILLION);
    end
  end

  ryc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (in_acc),
    .dir_i    (dir_r),
    .first_i  (in_first),
    .second_i (in_second),
    .third_i  (in_third),
    .denom_i  (denom_r),
    .half_i   (half_r),
    .ctl_o    (front_ctl),
    .num_o    (front_num)
  );

  ryc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (front_ctl),
    .num_i  (front_num),
    .dfwd_i (dfwd_r),
    .ctl_o  (div_ctl),
    .q_o    (div_q)
  );

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      mag[ch]  = div_q[ch][Q_W-1] ? MAG_CAP : {1'b0, div_q[ch][Q_W-2:0]};
      sval[ch] = div_ctl.neg[ch] ? -$signed({1'b0, mag[ch]}) : $signed({1'b0, mag[ch]});
    end
    if (div_ctl.dir == DIR_REV) begin
      out_first_nxt  = div_q[0][OUT0_W-1:0];
      out_second_nxt = {1'b0, div_q[1][OUT0_W-1:0]};
      out_third_nxt  = {1'b0, div_q[2][OUT0_W-1:0]};
    end else begin
      if (sval[0] < 0) begin
        out_first_nxt = '0;
      end else if (sval[0] > Y_MAX) begin
        out_first_nxt = '1;
      end else begin
        out_first_nxt = sval[0][OUT0_W-1:0];
      end
      out_second_nxt = chroma_sat(sval[1]);
      out_third_nxt  = chroma_sat(sval[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_third_r  <= out_third_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_third  = out_third_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("An accepted transaction produced no result.");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("A result appeared without an accepted transaction.");

  a_reverse_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (div_ctl.vld && div_ctl.dir == DIR_REV) |->
      (div_q[0] <= Q_W'(denom_r) && div_q[1] <= Q_W'(denom_r) &&
       div_q[2] <= Q_W'(denom_r)))
    else $error("Reverse quotient exceeds the denominator.");

endmodule

`default_nettype wire

FILE: bench/rgb_ypbpr_convert_tb.sv
// Self-checking testbench for the RGB / YPbPr color converter.
`timescale 1ns / 100ps

module rgb_ypbpr_convert_tb
  import ryc_pkg::*;
();

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 30;
  localparam longint MILLIONTHS = 1000000;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam logic signed [IN_W-1:0] S_MIN = 17'h10000;
  localparam logic signed [IN_W-1:0] S_MAX = 17'h0FFFF;

  typedef struct {
    logic [OUT0_W-1:0]         first;
    logic signed [OUT12_W-1:0] second;
    logic signed [OUT12_W-1:0] third;
  } pixel_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [OUT0_W-1:0]          in_first;
  logic signed [IN_W-1:0]     in_second;
  logic signed [IN_W-1:0]     in_third;
  logic                       out_valid;
  logic [OUT0_W-1:0]          out_first;
  logic signed [OUT12_W-1:0]  out_second;
  logic signed [OUT12_W-1:0]  out_third;
  logic                       cfg_we;
  logic [REG_IDX_W-1:0]       cfg_index;
  logic [DENOM_W-1:0]         cfg_data;

  pixel_t               pending_pixels[$];
  logic                 model_dir;
  logic [DENOM_W-1:0]   model_den;
  int                   gap_pct;
  int                   fault_count;
  int                   idle_cycles;

  rgb_ypbpr_convert #(.FRAC_BITS(FRAC)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_first   (in_first),
    .in_second  (in_second),
    .in_third   (in_third),
    .out_valid  (out_valid),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_div(input longint n, input longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint matrix_row(input longint a, input longint b, input longint c,
                                        input longint ka, input longint kb, input longint kc,
                                        input longint den);
    longint total;
    total = ka * a + kb * b + kc * c;
    return round_div(total * ONE_Q, MILLIONTHS * den);
  endfunction

  function automatic longint unit_to_sample(input longint v, input longint den);
    longint full;
    full = MILLIONTHS * ONE_Q;
    return (clip(v, 0, full) * den) / full;
  endfunction

  function automatic pixel_t convert_pixel(input logic dir, input logic [DENOM_W-1:0] den_reg,
                                           input logic [OUT0_W-1:0] f,
                                           input logic signed [IN_W-1:0] s,
                                           input logic signed [IN_W-1:0] t);
    pixel_t px;
    longint a;
    longint b;
    longint c;
    longint den;
    longint y;
    longint r0;
    longint r1;
    longint r2;
    a = longint'(f);
    b = longint'(s);
    c = longint'(t);
    den = (den_reg == 0) ? longint'(1) : longint'(den_reg);
    if (dir == DIR_FWD) begin
      r0 = clip(matrix_row(a, b, c, 299000, 587000, 114000, den), 0, 65535);
      r1 = clip(matrix_row(a, b, c, -168736, -331264, 500000, den), -32768, 65535);
      r2 = clip(matrix_row(a, b, c, 500000, -418688, -81312, den), -32768, 65535);
    end else begin
      y = MILLIONTHS * a;
      r0 = unit_to_sample(y + 1402000 * c, den);
      r1 = unit_to_sample(y - 344136 * b - 714136 * c, den);
      r2 = unit_to_sample(y + 1772000 * b, den);
    end
    px.first = r0[OUT0_W-1:0];
    px.second = r1[OUT12_W-1:0];
    px.third = r2[OUT12_W-1:0];
    return px;
  endfunction

  task automatic note_fault(input string what, input longint want, input longint got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    pixel_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_pixels.size() == 0) begin
        note_fault("result with no transaction outstanding", 0, longint'(out_first));
      end else begin
        want = pending_pixels.pop_front();
        if (out_first !== want.first)
          note_fault("out_first", longint'(want.first), longint'(out_first));
        if (out_second !== want.second)
          note_fault("out_second", longint'(want.second), longint'(out_second));
        if (out_third !== want.third)
          note_fault("out_third", longint'(want.third), longint'(out_third));
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [OUT0_W-1:0] f, input logic signed [IN_W-1:0] s,
                            input logic signed [IN_W-1:0] t);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_first <= f;
    in_second <= s;
    in_third <= t;
    do @(posedge clk); while (busy !== 1'b0);
    pending_pixels.push_back(convert_pixel(model_dir, model_den, f, s, t));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic dir, input logic [DENOM_W-1:0] den);
    logic [DENOM_W-1:0] junk;
    drain();
    junk = DENOM_W'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= REG_DIRECTION;
    cfg_data <= {junk[DENOM_W-1:1], dir};
    @(posedge clk);
    cfg_index <= REG_DENOM;
    cfg_data <= den;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_dir = dir;
    model_den = den;
  endtask

  task automatic send_random_pixel;
    logic [OUT0_W-1:0]      f;
    logic signed [IN_W-1:0] s;
    logic signed [IN_W-1:0] t;
    int                     tmp;
    if ($urandom_range(0, 9) < 8) begin
      if (model_dir == DIR_FWD) begin
        f = OUT0_W'($urandom_range(0, model_den));
        s = IN_W'($urandom_range(0, model_den));
        t = IN_W'($urandom_range(0, model_den));
      end else begin
        f = OUT0_W'($urandom);
        tmp = $urandom_range(0, 65535) - 32768;
        s = tmp[IN_W-1:0];
        tmp = $urandom_range(0, 65535) - 32768;
        t = tmp[IN_W-1:0];
      end
    end else begin
      f = OUT0_W'($urandom);
      s = IN_W'($urandom);
      t = IN_W'($urandom);
    end
    send_pixel(f, s, t);
  endtask

  task automatic test_reset_defaults;
    send_pixel(16'd0, 17'sd0, 17'sd0);
    send_pixel(16'd255, 17'sd255, 17'sd255);
    send_pixel(16'd255, 17'sd0, 17'sd0);
  endtask

  task automatic test_forward_corners;
    configure(DIR_FWD, 16'd255);
    send_pixel(16'd0, 17'sd0, 17'sd255);
    send_pixel(16'hFFFF, S_MAX, S_MAX);
    send_pixel(16'd0, S_MIN, S_MIN);
    send_pixel(16'hFFFF, S_MIN, S_MAX);
    send_pixel(16'd0, S_MAX, S_MIN);
  endtask

  task automatic test_denominator_corners;
    configure(DIR_FWD, 16'd0);
    send_pixel(16'd1, 17'sd1, 17'sd1);
    send_pixel(16'd0, 17'sd0, 17'sd1);
    configure(DIR_FWD, 16'hFFFF);
    send_pixel(16'hFFFF, 17'sd65535, 17'sd65535);
    send_pixel(16'd32768, 17'sd12345, 17'sd54321);
    configure(DIR_REV, 16'd0);
    send_pixel(16'hFFFF, 17'sd0, 17'sd0);
    send_pixel(16'd40000, 17'sd1000, -17'sd1000);
    configure(DIR_REV, 16'hFFFF);
    send_pixel(16'hFFFF, 17'sd0, 17'sd0);
    send_pixel(16'hFFFF, S_MAX, S_MAX);
  endtask

  task automatic test_reverse_corners;
    configure(DIR_REV, 16'd255);
    send_pixel(16'd0, 17'sd0, 17'sd0);
    send_pixel(16'hFFFF, 17'sd32767, -17'sd32768);
    send_pixel(16'd32768, S_MIN, S_MAX);
    send_pixel(16'd0, S_MAX, S_MIN);
    send_pixel(16'd30000, -17'sd20000, 17'sd20000);
  endtask

  task automatic test_random_mixed;
    logic [DENOM_W-1:0] den;
    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 5))
        0: den = 16'd0;
        1: den = 16'd1;
        2: den = 16'd255;
        3: den = 16'hFFFF;
        4: den = 16'd1023;
        default: den = DENOM_W'($urandom);
      endcase
      configure(phase[0] ? DIR_REV : DIR_FWD, den);
      gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 40);
      repeat (120) send_random_pixel();
    end
  endtask

  task automatic test_steady_stream;
    logic [DENOM_W-1:0] den;
    den = DENOM_W'($urandom);
    configure(DIR_FWD, den);
    gap_pct = 0;
    repeat (75) send_random_pixel();
    configure(DIR_REV, den);
    repeat (75) send_random_pixel();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_first = '0;
    in_second = '0;
    in_third = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 20;
    model_dir = DIR_FWD;
    model_den = DENOM_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_forward_corners();
    test_denominator_corners();
    test_reverse_corners();
    test_random_mixed();
    test_steady_stream();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
